FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising edge, masked while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Property checked at every rising edge, reset included.
`define ASSERT_CLK_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_CLK_NR(label, clk, prop)

`endif

`endif

FILE: hdl/lpck_pkg.sv
// ----------------------------------------------------------------------------
// lpck_pkg
// Types and constants for the pixel colour key block.
// ----------------------------------------------------------------------------
package lpck_pkg;

  localparam int KEEP_SLOTS = 4;
  localparam int DROP_SLOTS = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int KEEP_CNT_W = 3;
  localparam int DROP_CNT_W = 2;

  // register indices
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_ONLY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_HIGH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_COUNT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_COLS  = 3'd6;

  // result codes
  localparam logic [7:0] ALPHA_KEEP  = 8'd255;
  localparam logic [7:0] ALPHA_DROP  = 8'd0;
  localparam logic [7:0] ALPHA_OTHER = 8'd128;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [7:0]                  tolerance;
    logic                        line_only;
    logic [KEEP_CNT_W-1:0]       keep_count;
    rgb_t [KEEP_SLOTS-1:0]       keep_colors;
    logic [DROP_CNT_W-1:0]       drop_count;
    rgb_t [DROP_SLOTS-1:0]       drop_colors;
  } cfg_t;

endpackage

FILE: hdl/lpck_cfg_regs.sv
// ----------------------------------------------------------------------------
// lpck_cfg_regs
// Configuration register file: tolerance, mode, key colour tables.
// ----------------------------------------------------------------------------
module lpck_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lpck_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpck_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output lpck_pkg::cfg_t                 cfg
);
  import lpck_pkg::*;

  logic [7:0]            tol_r;
  logic                  line_only_r;
  logic [KEEP_CNT_W-1:0] keep_cnt_r;
  logic [47:0]           keep_lo_r;
  logic [47:0]           keep_hi_r;
  logic [DROP_CNT_W-1:0] drop_cnt_r;
  logic [47:0]           drop_cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r       <= '0;
      line_only_r <= 1'b0;
      keep_cnt_r  <= '0;
      keep_lo_r   <= '0;
      keep_hi_r   <= '0;
      drop_cnt_r  <= '0;
      drop_cols_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOLERANCE:  tol_r       <= cfg_wdata[7:0];
        CFG_LINE_ONLY:  line_only_r <= cfg_wdata[0];
        CFG_KEEP_COUNT: keep_cnt_r  <= cfg_wdata[KEEP_CNT_W-1:0];
        CFG_KEEP_LOW:   keep_lo_r   <= cfg_wdata[47:0];
        CFG_KEEP_HIGH:  keep_hi_r   <= cfg_wdata[47:0];
        CFG_DROP_COUNT: drop_cnt_r  <= cfg_wdata[DROP_CNT_W-1:0];
        CFG_DROP_COLS:  drop_cols_r <= cfg_wdata[47:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.tolerance      = tol_r;
    cfg.line_only      = line_only_r;
    cfg.keep_count     = keep_cnt_r;
    cfg.keep_colors[0] = rgb_t'(keep_lo_r[23:0]);
    cfg.keep_colors[1] = rgb_t'(keep_lo_r[47:24]);
    cfg.keep_colors[2] = rgb_t'(keep_hi_r[23:0]);
    cfg.keep_colors[3] = rgb_t'(keep_hi_r[47:24]);
    cfg.drop_count     = drop_cnt_r;
    cfg.drop_colors[0] = rgb_t'(drop_cols_r[23:0]);
    cfg.drop_colors[1] = rgb_t'(drop_cols_r[47:24]);
  end

endmodule

FILE: hdl/lpck_color_cmp.sv
// ----------------------------------------------------------------------------
// lpck_color_cmp
// One colour comparator: all three channels within tolerance of the key.
// ----------------------------------------------------------------------------
module lpck_color_cmp (
  input  lpck_pkg::rgb_t pix,
  input  lpck_pkg::rgb_t key,
  input  logic [7:0]     tol,
  output logic           hit
);
  import lpck_pkg::*;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  assign hit = (abs_diff(pix.red,   key.red)   <= tol)
            && (abs_diff(pix.green, key.green) <= tol)
            && (abs_diff(pix.blue,  key.blue)  <= tol);

endmodule

FILE: hdl/lpck_classify.sv
// ----------------------------------------------------------------------------
// lpck_classify
// Parallel keep/drop comparators and the alpha decision.
// ----------------------------------------------------------------------------
module lpck_classify #(
  parameter int KEEP_LANES = 4,
  parameter int DROP_LANES = 2
) (
  input  lpck_pkg::cfg_t cfg,
  input  lpck_pkg::rgb_t pix,
  input  logic [7:0]     alpha,
  output logic [7:0]     mark
);
  import lpck_pkg::*;

  logic [KEEP_LANES-1:0] keep_match;
  logic [KEEP_LANES-1:0] keep_en;
  logic [DROP_LANES-1:0] drop_match;
  logic [DROP_LANES-1:0] drop_en;
  logic                  keep_hit;
  logic                  drop_hit;
  logic                  clear_pix;

  for (genvar i = 0; i < KEEP_LANES; i++) begin : g_keep
    lpck_color_cmp u_cmp (
      .pix (pix),
      .key (cfg.keep_colors[i]),
      .tol (cfg.tolerance),
      .hit (keep_match[i])
    );
    assign keep_en[i] = cfg.keep_count > KEEP_CNT_W'(i);
  end

  for (genvar j = 0; j < DROP_LANES; j++) begin : g_drop
    lpck_color_cmp u_cmp (
      .pix (pix),
      .key (cfg.drop_colors[j]),
      .tol (cfg.tolerance),
      .hit (drop_match[j])
    );
    assign drop_en[j] = cfg.drop_count > DROP_CNT_W'(j);
  end

  assign keep_hit  = |(keep_match & keep_en);
  assign drop_hit  = |(drop_match & drop_en);
  assign clear_pix = (alpha == 8'd0) || (pix == rgb_t'(24'hFF_FFFF));

  always_comb begin
    if (keep_hit) begin
      mark = ALPHA_KEEP;
    end else if (cfg.line_only || drop_hit || clear_pix) begin
      mark = ALPHA_DROP;
    end else begin
      mark = ALPHA_OTHER;
    end
  end

endmodule

FILE: hdl/line_pixel_color_key_top.sv
// ----------------------------------------------------------------------------
// line_pixel_color_key_top
// RGB colour key with tolerance: classifies each pixel into an alpha mark.
//
//   Channel  Ports                                  Dir  Beat
//   in       in_valid/in_stall, in_red..in_alpha    in   one RGBA pixel
//   out      out_valid/out_stall, out_mark_alpha    out  one 8-bit mark
//   cfg      cfg_we, cfg_index, cfg_wdata           in   one register write
//
// Each input beat passes the pixel register, the single comparator bank
// and the result register; one pixel per clock while out_stall is low.
// Synchronous active-low reset clears both valids and the configuration
// registers; the pixel and mark registers are not reset.
// out_stall holds the result register; the pixel register keeps taking
// beats until both stages are full.
// ----------------------------------------------------------------------------
module line_pixel_color_key_top #(
  parameter int MAX_KEEP = 4,
  parameter int MAX_DROP = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lpck_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpck_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_red,
  input  logic [7:0]                      in_green,
  input  logic [7:0]                      in_blue,
  input  logic [7:0]                      in_alpha,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_mark_alpha
);
  import lpck_pkg::*;

  `include "assert_macros.svh"

  localparam int KEEP_LANES = (MAX_KEEP < KEEP_SLOTS) ? MAX_KEEP : KEEP_SLOTS;
  localparam int DROP_LANES = (MAX_DROP < DROP_SLOTS) ? MAX_DROP : DROP_SLOTS;

  cfg_t       cfg;
  rgb_t       pix_r;
  logic [7:0] alpha_r;
  logic       s1_vld_r;
  logic       s1_vld_nxt;
  logic [7:0] mark_nxt;
  logic [7:0] mark_r;
  logic       out_vld_r;
  logic       out_vld_nxt;
  logic       s1_ld;
  logic       s2_ld;

  lpck_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lpck_classify #(
    .KEEP_LANES (KEEP_LANES),
    .DROP_LANES (DROP_LANES)
  ) u_cls (
    .cfg   (cfg),
    .pix   (pix_r),
    .alpha (alpha_r),
    .mark  (mark_nxt)
  );

  assign s2_ld    = !out_vld_r || !out_stall;
  assign s1_ld    = !s1_vld_r || s2_ld;
  assign in_stall = !s1_ld;

  assign s1_vld_nxt  = s1_ld ? in_valid : s1_vld_r;
  assign out_vld_nxt = s2_ld ? s1_vld_r : out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ld) begin
      pix_r   <= '{red: in_red, green: in_green, blue: in_blue};
      alpha_r <= in_alpha;
    end
    if (s2_ld && s1_vld_r) begin
      mark_r <= mark_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_mark_alpha = mark_r;

  `ASSERT_CLK(a_stall_only_full, clk, rst_n,
    in_stall |-> (s1_vld_r && out_vld_r && out_stall))
  `ASSERT_CLK(a_in_beat_taken, clk, rst_n,
    (in_valid && !in_stall) |=> s1_vld_r)
  `ASSERT_CLK(a_stage_moves, clk, rst_n,
    (s1_vld_r && s2_ld) |=> out_vld_r)
  `ASSERT_CLK(a_line_only_codes, clk, rst_n,
    (out_vld_r && cfg.line_only) |->
      (mark_r == ALPHA_KEEP || mark_r == ALPHA_DROP))

endmodule
